[hw/rtl/pta_pkg.sv]
`default_nettype none
package pta_pkg;

  // Fixed widths of the channel fields.
  localparam int IDX_W  = 32;
  localparam int MODE_W = 2;
  localparam int SLOT_W = 2;

  // Default internal index width and the depth of the job queue.
  localparam int INDEX_BITS_DEFAULT = 32;
  localparam int QUEUE_DEPTH        = 2;

  // Item kinds.
  localparam logic ITEM_MARKER = 1'b0;
  localparam logic ITEM_VERTEX = 1'b1;

  // Primitive modes; MODE_NONE doubles as the unrecognized marker code.
  localparam logic [MODE_W-1:0] MODE_TRI  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUAD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POLY = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

  // Highest corner slot of a triple, also the highest position within a job.
  localparam logic [SLOT_W-1:0] SLOT_LAST = 2'd2;

  // Corner count at which quads close and polygons start fanning.
  localparam logic [1:0] CORNERS_FULL = 2'd3;

endpackage
`default_nettype wire

[hw/rtl/pta_if.sv]
`default_nettype none
interface pta_in_if;
  logic                            valid;
  logic                            ready;
  logic                            item_kind;
  logic [pta_pkg::MODE_W-1:0]      prim_mode;
  logic [pta_pkg::IDX_W-1:0]       vertex_index;

  modport source (output valid, item_kind, prim_mode, vertex_index, input ready);
  modport sink   (input valid, item_kind, prim_mode, vertex_index, output ready);
endinterface

interface pta_out_if;
  logic                            valid;
  logic                            ready;
  logic [pta_pkg::IDX_W-1:0]       tri_index;
  logic [pta_pkg::SLOT_W-1:0]      corner_slot;
  logic                            last_of_run;

  modport source (output valid, tri_index, corner_slot, last_of_run, input ready);
  modport sink   (input valid, tri_index, corner_slot, last_of_run, output ready);
endinterface
`default_nettype wire

[hw/rtl/primitive_to_triangle_assembly_unit.sv]
`default_nettype none
// A vertex's first index reaches the result channel via the job queue and the output register.
// One index is sent per cycle while out_ch is ready, set by the single output register; a vertex
// that passes through sends one index, a quad close or fan step three; markers send none.
// Reset (rst, synchronous, active high): no mode selected, corner count, stored vertices and
// the corner slot cleared, job queue and output register empty.
module primitive_to_triangle_assembly_unit #(
  parameter int INDEX_BITS = pta_pkg::INDEX_BITS_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  pta_in_if.sink     in_ch,
  pta_out_if.source  out_ch
);

  // A job is the set of indices one vertex causes: a flag that tells one
  // index from three, and three index slots in emission order.
  localparam int JOB_W = 3 * INDEX_BITS + 1;

  logic                    front_valid;
  logic                    front_ready;
  logic                    front_triple;
  logic [3*INDEX_BITS-1:0] front_idx;

  logic                    back_valid;
  logic                    back_pop;
  logic [JOB_W-1:0]        back_job;

  // The front end keeps the mode, the corner count and the first and last
  // vertex, and decides which indices a vertex emits. It stalls only when
  // the job queue is full.
  pta_front #(
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .job_valid  (front_valid),
    .job_ready  (front_ready),
    .job_triple (front_triple),
    .job_idx    (front_idx)
  );

  // The queue lets the front end keep taking items while the back end is
  // still sending the three indices of a quad close or a fan step.
  pta_queue #(
    .WIDTH (JOB_W),
    .DEPTH (pta_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (front_valid),
    .push_ready (front_ready),
    .push_data  ({front_triple, front_idx}),
    .pop_valid  (back_valid),
    .pop        (back_pop),
    .pop_data   (back_job)
  );

  // The back end sends each index of the head job in turn, tags it with the
  // slot of the running stream and marks the last index of the job.
  pta_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (back_valid),
    .job_pop    (back_pop),
    .job_triple (back_job[JOB_W-1]),
    .job_idx    (back_job[JOB_W-2:0]),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire

[hw/rtl/pta_front.sv]
`default_nettype none
// Classifies input items, tracks the primitive state and turns each vertex
// into a job of one or three indices for the back end.
module pta_front #(
  parameter int INDEX_BITS = pta_pkg::INDEX_BITS_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  pta_in_if.sink                         in_ch,
  output logic                           job_valid,
  input  wire logic                      job_ready,
  output logic                           job_triple,
  output logic [3*INDEX_BITS-1:0]        job_idx
);

  logic [pta_pkg::MODE_W-1:0] mode;
  logic [1:0]                 corners;
  logic [INDEX_BITS-1:0]      first_vertex;
  logic [INDEX_BITS-1:0]      last_vertex;

  logic [INDEX_BITS-1:0]      v;
  logic                       accept;
  logic                       is_vertex;
  logic                       full_corners;

  assign in_ch.ready  = job_ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign is_vertex    = in_ch.item_kind == pta_pkg::ITEM_VERTEX;
  assign v            = in_ch.vertex_index[INDEX_BITS-1:0];
  assign full_corners = corners == pta_pkg::CORNERS_FULL;

  // A job is pushed for every vertex that arrives under a recognized mode.
  assign job_valid  = accept && is_vertex && (mode != pta_pkg::MODE_NONE);
  assign job_triple = (mode != pta_pkg::MODE_TRI) && full_corners;

  always_comb begin
    if (!job_triple) begin
      job_idx = {v, v, v};
    end else if (mode == pta_pkg::MODE_QUAD) begin
      job_idx = {first_vertex, v, last_vertex};
    end else begin
      job_idx = {v, last_vertex, first_vertex};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= pta_pkg::MODE_NONE;
      corners      <= 2'd0;
      first_vertex <= '0;
      last_vertex  <= '0;
    end else if (accept) begin
      if (!is_vertex) begin
        if (in_ch.prim_mode != pta_pkg::MODE_NONE) begin
          mode <= in_ch.prim_mode;
        end
        corners <= 2'd0;
      end else if (mode == pta_pkg::MODE_QUAD || mode == pta_pkg::MODE_POLY) begin
        last_vertex <= v;
        if (!full_corners) begin
          if (corners == 2'd0) begin
            first_vertex <= v;
          end
          corners <= corners + 2'd1;
        end else if (mode == pta_pkg::MODE_QUAD) begin
          corners <= 2'd0;
        end
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/pta_queue.sv]
`default_nettype none
// Small register queue that decouples the front end from the back end.
module pta_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = pta_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign push_ready = count != CNT_MAX;
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_MAX) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_MAX) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/pta_back.sv]
`default_nettype none
// Sends the head job of the queue, one index per cycle while out_ch is
// ready, through the output register, keeping the running corner slot.
module pta_back #(
  parameter int INDEX_BITS = pta_pkg::INDEX_BITS_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      job_valid,
  output logic                           job_pop,
  input  wire logic                      job_triple,
  input  wire logic [3*INDEX_BITS-1:0]   job_idx,
  pta_out_if.source                      out_ch
);

  localparam int IW = pta_pkg::IDX_W;
  localparam int SW = pta_pkg::SLOT_W;

  logic [SW-1:0]         pos;
  logic [SW-1:0]         slot;
  logic                  out_valid;
  logic [INDEX_BITS-1:0] out_index;
  logic [SW-1:0]         out_slot;
  logic                  out_last;

  logic                  load;
  logic                  is_last;
  logic [INDEX_BITS-1:0] sel_index;

  assign load    = job_valid && (!out_valid || out_ch.ready);
  assign is_last = !job_triple || (pos == pta_pkg::SLOT_LAST);
  assign job_pop = load && is_last;

  always_comb begin
    case (pos)
      2'd0:    sel_index = job_idx[INDEX_BITS-1:0];
      2'd1:    sel_index = job_idx[2*INDEX_BITS-1:INDEX_BITS];
      default: sel_index = job_idx[3*INDEX_BITS-1:2*INDEX_BITS];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      slot      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        pos       <= is_last ? '0 : pos + SW'(1);
        slot      <= (slot == pta_pkg::SLOT_LAST) ? '0 : slot + SW'(1);
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_index <= sel_index;
      out_slot  <= slot;
      out_last  <= is_last;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.tri_index   = IW'(out_index);
  assign out_ch.corner_slot = out_slot;
  assign out_ch.last_of_run = out_last;

endmodule
`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import pta_pkg::*;

  // The block runs at its full index width; the predictor masks to the same width.
  localparam int ASM_INDEX_BITS = 32;

  // Cycles to let pass once nothing is pending, to cover the latency of the block
  // and the last transfer of a three-index fan step.
  localparam int SETTLE_CYCLES = 8;

  // One emitted triangle corner as it appears on the result channel.
  typedef struct packed {
    logic [IDX_W-1:0]  tri_index;
    logic [SLOT_W-1:0] corner_slot;
    logic              last_of_run;
  } corner_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pta_in_if  in_ch ();
  pta_out_if out_ch ();

  primitive_to_triangle_assembly_unit #(
    .INDEX_BITS(ASM_INDEX_BITS)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // Corners that the block owes us, oldest first.
  corner_t pending_corners[$];

  // Shadow copy of the assembly state, advanced once per accepted transfer.
  logic [MODE_W-1:0] asm_mode;
  logic [1:0]        asm_corners;
  logic [IDX_W-1:0]  asm_first;
  logic [IDX_W-1:0]  asm_prev;
  logic [SLOT_W-1:0] asm_slot;

  int fail_count = 0;
  int items_sent = 0;

  // Idling controls. The sender and the receiver each roll against these
  // percentages once per cycle; hold_left forces a long receiver stall.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_left     = 0;

  // Appends one corner to the expected stream and moves the running slot on.
  // The slot follows the whole output stream and is never cleared by a marker.
  function automatic void emit_corner(input logic [IDX_W-1:0] v);
    corner_t c;
    c.tri_index   = v;
    c.corner_slot = asm_slot;
    c.last_of_run = 1'b0;
    pending_corners.push_back(c);
    asm_slot = (asm_slot >= SLOT_LAST) ? '0 : asm_slot + 1'b1;
  endfunction

  // Works out the corners that one accepted item produces.
  function automatic void assemble_item(input logic kind, input logic [MODE_W-1:0] mode,
                                        input logic [IDX_W-1:0] vidx);
    logic [IDX_W-1:0] v;
    int               emitted;
    v = vidx & IDX_W'((64'd1 << ASM_INDEX_BITS) - 1);
    emitted = 0;
    if (kind == ITEM_MARKER) begin
      // An unrecognized marker keeps the mode but still restarts the primitive.
      if (mode != MODE_NONE) asm_mode = mode;
      asm_corners = '0;
      return;
    end
    case (asm_mode)
      MODE_TRI: begin
        emit_corner(v);
        emitted = 1;
      end
      MODE_QUAD: begin
        if (asm_corners < CORNERS_FULL) begin
          if (asm_corners == '0) asm_first = v;
          emit_corner(v);
          emitted = 1;
          asm_corners = asm_corners + 1'b1;
        end else begin
          // The fourth corner closes the second triangle of the quad.
          emit_corner(asm_prev);
          emit_corner(v);
          emit_corner(asm_first);
          emitted = 3;
          asm_corners = '0;
        end
        asm_prev = v;
      end
      MODE_POLY: begin
        if (asm_corners < CORNERS_FULL) begin
          if (asm_corners == '0) asm_first = v;
          emit_corner(v);
          emitted = 1;
          asm_corners = asm_corners + 1'b1;
        end else begin
          // Fan step: the corner count stays saturated.
          emit_corner(asm_first);
          emit_corner(asm_prev);
          emit_corner(v);
          emitted = 3;
        end
        asm_prev = v;
      end
      default: begin
        // No mode has been selected yet, so the vertex is dropped.
      end
    endcase
    if (emitted > 0) pending_corners[pending_corners.size()-1].last_of_run = 1'b1;
  endfunction

  // Offers one item from the falling edge, waits for its transfer, then
  // records what it should produce. Valid stays high on return so that
  // back-to-back items need no gap.
  task automatic send_item(input logic kind, input logic [MODE_W-1:0] mode,
                           input logic [IDX_W-1:0] vidx);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.item_kind    = kind;
    in_ch.prim_mode    = mode;
    in_ch.vertex_index = vidx;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    assemble_item(kind, mode, vidx);
    items_sent++;
  endtask

  // Stops offering items and waits until every owed corner has arrived.
  task automatic wait_for_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_corners.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [IDX_W-1:0] pick_index();
    case ($urandom_range(3))
      0: return IDX_W'($urandom_range(255));
      1: return ($urandom_range(1) != 0) ? '1 : '0;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: the ready line is rolled at every falling edge, unless a long
  // hold-off has been requested, which this process counts down itself.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Every result transfer is compared with the oldest owed corner.
  always @(posedge clk) begin : check_corners
    corner_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_corners.size() == 0) begin
        $display("%0t: unexpected result index %h slot %0d last %b", $time,
                 out_ch.tri_index, out_ch.corner_slot, out_ch.last_of_run);
        fail_count++;
      end else begin
        want = pending_corners.pop_front();
        if (out_ch.tri_index !== want.tri_index) begin
          $display("%0t: tri_index expected %h got %h", $time,
                   want.tri_index, out_ch.tri_index);
          fail_count++;
        end
        if (out_ch.corner_slot !== want.corner_slot) begin
          $display("%0t: corner_slot expected %0d got %0d", $time,
                   want.corner_slot, out_ch.corner_slot);
          fail_count++;
        end
        if (out_ch.last_of_run !== want.last_of_run) begin
          $display("%0t: last_of_run expected %b got %b", $time,
                   want.last_of_run, out_ch.last_of_run);
          fail_count++;
        end
      end
    end
  end

  // Right after reset no mode is selected: vertices vanish, and an
  // unrecognized marker does not select one either.
  task automatic test_vertex_before_mode();
    send_item(ITEM_VERTEX, MODE_POLY, 32'h1234_5678);
    send_item(ITEM_MARKER, MODE_NONE, 32'hFFFF_FFFF);
    send_item(ITEM_VERTEX, MODE_NONE, 32'hFFFF_FFFF);
    wait_for_results();
  endtask

  // Triangle mode passes each index through. Three corners plus a stray
  // fourth leave the slot counter off a triple boundary for later tests.
  task automatic test_triangle_pass();
    send_item(ITEM_MARKER, MODE_TRI, 32'hFFFF_FFFF);
    send_item(ITEM_VERTEX, MODE_NONE, 32'h0000_0000);
    send_item(ITEM_VERTEX, MODE_QUAD, 32'hFFFF_FFFF);
    send_item(ITEM_VERTEX, MODE_TRI, 32'hA5A5_A5A5);
    send_item(ITEM_VERTEX, MODE_POLY, 32'h8000_0001);
    wait_for_results();
  endtask

  // A full quad, then a quad broken off after one corner by an unrecognized
  // marker, which keeps quad mode but restarts the corner count.
  task automatic test_quad_close();
    send_item(ITEM_MARKER, MODE_QUAD, 32'h0);
    send_item(ITEM_VERTEX, MODE_TRI, 32'h0000_0010);
    send_item(ITEM_VERTEX, MODE_TRI, 32'h0000_0011);
    send_item(ITEM_VERTEX, MODE_TRI, 32'hFFFF_FFFE);
    send_item(ITEM_VERTEX, MODE_TRI, 32'h7FFF_FFFF);
    send_item(ITEM_VERTEX, MODE_TRI, 32'h0000_00AA);
    send_item(ITEM_MARKER, MODE_NONE, 32'h5555_5555);
    send_item(ITEM_VERTEX, MODE_TRI, 32'h0000_0020);
    send_item(ITEM_VERTEX, MODE_TRI, 32'h0000_0021);
    send_item(ITEM_VERTEX, MODE_TRI, 32'h0000_0022);
    send_item(ITEM_VERTEX, MODE_TRI, 32'h0000_0023);
    wait_for_results();
  endtask

  // A polygon fan past the saturation point, then an unrecognized marker
  // that keeps polygon mode and starts a new fan.
  task automatic test_polygon_fan();
    send_item(ITEM_MARKER, MODE_POLY, 32'hCAFE_0000);
    send_item(ITEM_VERTEX, MODE_NONE, 32'h0000_0001);
    send_item(ITEM_VERTEX, MODE_NONE, 32'h0000_0002);
    send_item(ITEM_VERTEX, MODE_NONE, 32'h0000_0003);
    send_item(ITEM_VERTEX, MODE_NONE, 32'hFFFF_FFFF);
    send_item(ITEM_VERTEX, MODE_NONE, 32'h0000_0000);
    send_item(ITEM_MARKER, MODE_NONE, 32'h0);
    send_item(ITEM_VERTEX, MODE_NONE, 32'h0000_0099);
    wait_for_results();
  endtask

  // The receiver holds off for a long stretch while a fan keeps coming, so
  // the job queue fills and the block has to refuse input transfers.
  task automatic test_output_backpressure();
    @(posedge clk);
    hold_left = 60;
    send_item(ITEM_MARKER, MODE_POLY, 32'h0);
    for (int k = 0; k < 10; k++) send_item(ITEM_VERTEX, MODE_POLY, pick_index());
    wait_for_results();
  endtask

  // Mostly well-formed primitives with random content: a mode marker and a
  // run of vertices. Some quads are cut short, some runs are broken by an
  // unrecognized marker, and a few items are pure noise.
  task automatic random_primitives(input int n_items, input int idle_pct, input int stall);
    int                stop_at;
    int                run_len;
    logic [MODE_W-1:0] mode;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    stop_at       = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 8) begin
        send_item(1'($urandom_range(1)), MODE_W'($urandom_range(3)), $urandom);
      end else begin
        mode = MODE_W'($urandom_range(2));
        send_item(ITEM_MARKER, mode, $urandom);
        case (mode)
          MODE_TRI:  run_len = $urandom_range(6, 1);
          MODE_QUAD: run_len = ($urandom_range(4) == 0) ? $urandom_range(7, 1)
                                                        : 4 * $urandom_range(3, 1);
          default:   run_len = $urandom_range(9, 3);
        endcase
        for (int k = 0; k < run_len; k++) begin
          if ($urandom_range(99) < 4) send_item(ITEM_MARKER, MODE_NONE, $urandom);
          send_item(ITEM_VERTEX, MODE_W'($urandom_range(3)), pick_index());
        end
      end
    end
    wait_for_results();
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.item_kind    = ITEM_MARKER;
    in_ch.prim_mode    = MODE_TRI;
    in_ch.vertex_index = '0;
    asm_mode    = MODE_NONE;
    asm_corners = '0;
    asm_first   = '0;
    asm_prev    = '0;
    asm_slot    = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_vertex_before_mode();
    test_triangle_pass();
    test_quad_close();
    test_polygon_fan();
    test_output_backpressure();

    // Random phases: free running, idle sender, stalling receiver, both.
    random_primitives(80, 0, 0);
    random_primitives(80, 48, 0);
    random_primitives(80, 0, 48);
    random_primitives(90, 33, 33);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // A hung handshake ends the run here; a clean run takes well under this.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/pta_pkg.sv
hw/rtl/pta_if.sv
hw/rtl/pta_front.sv
hw/rtl/pta_queue.sv
hw/rtl/pta_back.sv
hw/rtl/primitive_to_triangle_assembly_unit.sv
bench/tb_top.sv
